FILE: src/keyframe_track_lerp_sampler_top_macros.svh
// ----------------------------------------------------------------------------
// keyframe track sampler assertion macros
// shared concurrent assertion helpers, clocked on clk_i, gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_TRACK_LERP_SAMPLER_TOP_MACROS_SVH
`define KEYFRAME_TRACK_LERP_SAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define KTLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define KTLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/ktls_pkg.sv
// ----------------------------------------------------------------------------
// ktls_pkg
// shared widths, types and codes of the keyframe track sampler
// ----------------------------------------------------------------------------
package ktls_pkg;

  localparam int unsigned KEYS_DEF  = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned KCNT_W    = 7;
  localparam int unsigned SLOT_W    = 6;

  // request command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // one link of the divider chain
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] den;
    logic [FRAC_W-1:0] quo;
  } div_link_t;

endpackage

FILE: src/ktls_div_cell.sv
// ----------------------------------------------------------------------------
// ktls_div_cell
// one restoring division step, registered, passed to the next cell
// ----------------------------------------------------------------------------
module ktls_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ktls_pkg::div_link_t   link_i,
  output ktls_pkg::div_link_t   link_o
);
  import ktls_pkg::*;

  logic [WORD_W:0]   rem2;
  logic              ge;
  logic              vld_q;
  logic [WORD_W-1:0] rem_q;
  logic [WORD_W-1:0] den_q;
  logic [FRAC_W-1:0] quo_q;

  // shift in a zero bit, subtract the divisor when it fits
  always_comb begin
    rem2 = {link_i.rem, 1'b0};
    ge   = (rem2 >= {1'b0, link_i.den});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= link_i.vld;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    rem_q <= ge ? WORD_W'(rem2 - {1'b0, link_i.den}) : rem2[WORD_W-1:0];
    den_q <= link_i.den;
    quo_q <= {link_i.quo[FRAC_W-2:0], ge};
  end

  assign link_o = {vld_q, rem_q, den_q, quo_q};

endmodule

FILE: src/ktls_div_chain.sv
// ----------------------------------------------------------------------------
// ktls_div_chain
// row of division cells, one quotient bit per cell
// ----------------------------------------------------------------------------
module ktls_div_chain (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ktls_pkg::div_link_t   link_i,
  output ktls_pkg::div_link_t   link_o
);
  import ktls_pkg::*;

  div_link_t links [FRAC_W+1];

  assign links[0] = link_i;

  // cells hand remainder and partial quotient down the row
  for (genvar g = 0; g < FRAC_W; g++) begin : g_cell
    ktls_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (links[g]),
      .link_o (links[g+1])
    );
  end

  assign link_o = links[FRAC_W];

endmodule

FILE: src/ktls_lerp_axis.sv
// ----------------------------------------------------------------------------
// ktls_lerp_axis
// one axis of the interpolation: registered product, then add and saturate
// ----------------------------------------------------------------------------
module ktls_lerp_axis (
  input  logic                                clk_i,
  input  logic                                mul_en_i,
  input  logic signed [ktls_pkg::WORD_W-1:0]  a_i,
  input  logic signed [ktls_pkg::WORD_W-1:0]  b_i,
  input  logic        [ktls_pkg::FRAC_W-1:0]  frac_i,
  output logic signed [ktls_pkg::WORD_W-1:0]  res_o
);
  import ktls_pkg::*;

  localparam int unsigned PW = WORD_W + FRAC_W + 2;
  localparam int unsigned SW = WORD_W + 3;

  logic signed [WORD_W:0]   diff;
  logic signed [PW-1:0]     prod_q;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     max_v;
  logic signed [SW-1:0]     min_v;

  // difference of the end points times the fraction
  assign diff = $signed({b_i[WORD_W-1], b_i}) - $signed({a_i[WORD_W-1], a_i});

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= diff * $signed({1'b0, frac_i});
    end
  end

  // floor shift of the product, add start point, saturate
  always_comb begin
    sum   = $signed({{3{a_i[WORD_W-1]}}, a_i}) +
            $signed({prod_q[PW-1], prod_q[PW-1:FRAC_W]});
    max_v = $signed({3'b000, 1'b0, {(WORD_W-1){1'b1}}});
    min_v = $signed({3'b111, 1'b1, {(WORD_W-1){1'b0}}});
    if (sum > max_v) begin
      res_o = max_v[WORD_W-1:0];
    end else if (sum < min_v) begin
      res_o = min_v[WORD_W-1:0];
    end else begin
      res_o = sum[WORD_W-1:0];
    end
  end

endmodule

FILE: src/keyframe_track_lerp_sampler_top.sv
// ----------------------------------------------------------------------------
// keyframe_track_lerp_sampler_top
// keyframe table with linear search, divider cell row and per-axis lerp
// ----------------------------------------------------------------------------
// Usage:
//   Requests come on in_valid_i/in_ready_o. cmd_i low loads a key into
//   key_slot_i (no result); cmd_i high samples the track at
//   sample_time_i and gives one result on out_valid_o/out_ready_i.
//   key_count is written through cfg_we_i/cfg_wdata_i; the user must do
//   so only while idle, and the block itself does not enforce this.
//   A sample scans the table one key per cycle through its single read
//   port, then passes the divider cell row when the time falls inside the
//   track, then the multiply and add states; a clamped sample skips the
//   divider.
//   Requests are taken one at a time; a new request is accepted while the
//   previous result still waits in the output register, and the block holds
//   its next result until the receiver takes the waiting one.
//   Reset empties the output, sets key_count to 1 and leaves the table
//   contents undefined until loaded.
// ----------------------------------------------------------------------------
`include "keyframe_track_lerp_sampler_top_macros.svh"

module keyframe_track_lerp_sampler_top #(
  parameter int unsigned KEYS = ktls_pkg::KEYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [ktls_pkg::KCNT_W-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic        [ktls_pkg::SLOT_W-1:0]  key_slot_i,
  input  logic        [ktls_pkg::WORD_W-1:0]  key_stamp_i,
  input  logic signed [ktls_pkg::WORD_W-1:0]  key_x_i,
  input  logic signed [ktls_pkg::WORD_W-1:0]  key_y_i,
  input  logic signed [ktls_pkg::WORD_W-1:0]  key_z_i,
  input  logic        [ktls_pkg::WORD_W-1:0]  sample_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ktls_pkg::WORD_W-1:0]  out_x_o,
  output logic signed [ktls_pkg::WORD_W-1:0]  out_y_o,
  output logic signed [ktls_pkg::WORD_W-1:0]  out_z_o,
  output logic                                clamped_o
);
  import ktls_pkg::*;

  localparam int unsigned AW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned KW = 4 * WORD_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_ADD  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [KCNT_W-1:0]   kcnt_q;
  logic [AW:0]         n_keys;
  logic [AW-1:0]       last_idx;
  logic [KW-1:0]       mem_q [KEYS];
  logic [KW-1:0]       rd_q;
  logic [KW-1:0]       prev_q;
  logic [AW-1:0]       ra_q;
  logic [AW-1:0]       idx_q;
  logic                dv_q;
  logic [WORD_W-1:0]   time_q;
  logic [3*WORD_W-1:0] a_q, b_q;
  logic [FRAC_W-1:0]   frac_q;
  logic                flag_q;
  logic                out_valid_q;
  logic [WORD_W-1:0]   ox_q, oy_q, oz_q;
  logic                oc_q;
  logic                acc_in, acc_sample, acc_load;
  logic [WORD_W-1:0]   cur_stamp, prev_stamp;
  logic                hit, done_clamp, done_found;
  logic [3*WORD_W-1:0] sel_key;
  logic                sel_flag;
  div_link_t           div_in, div_out;
  logic [WORD_W-1:0]   rx, ry, rz;
  logic                out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;
  assign acc_sample = acc_in && (cmd_i == CMD_SAMPLE);
  assign acc_load   = acc_in && (cmd_i == CMD_LOAD);
  assign out_free   = !out_valid_q || out_ready_i;

  // key count in use, clamped to 1..KEYS
  always_comb begin
    if (kcnt_q == '0) begin
      n_keys = (AW+1)'(1);
    end else if (int'(kcnt_q) > int'(KEYS)) begin
      n_keys = (AW+1)'(KEYS);
    end else begin
      n_keys = (AW+1)'(kcnt_q);
    end
    last_idx = AW'(n_keys - (AW+1)'(1));
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcnt_q <= KCNT_W'(1);
    end else if (cfg_we_i) begin
      kcnt_q <= cfg_wdata_i;
    end
  end

  // key table: stamp and vector in one word, one write and one read port
  always_ff @(posedge clk_i) begin
    if (acc_load && (int'(key_slot_i) < int'(KEYS))) begin
      mem_q[AW'(key_slot_i)] <= {key_stamp_i, key_x_i, key_y_i, key_z_i};
    end
    rd_q <= mem_q[ra_q];
  end

  // scan compare on the key word read last cycle
  always_comb begin
    cur_stamp  = rd_q[KW-1 -: WORD_W];
    prev_stamp = prev_q[KW-1 -: WORD_W];
    hit        = time_q < cur_stamp;
    done_clamp = 1'b0;
    done_found = 1'b0;
    sel_key    = rd_q[3*WORD_W-1:0];
    sel_flag   = 1'b1;
    if (state_q == ST_SCAN && dv_q) begin
      if (idx_q == '0) begin
        if (n_keys == (AW+1)'(1)) begin
          done_clamp = 1'b1;
          sel_flag   = 1'b0;
        end else if (hit) begin
          done_clamp = 1'b1;
        end
      end else if (hit) begin
        done_found = 1'b1;
      end else if (idx_q == last_idx) begin
        done_clamp = 1'b1;
      end
    end
  end

  // divider feed: zero fraction when the segment starts after the time
  always_comb begin
    div_in.vld = done_found;
    div_in.quo = '0;
    if (time_q >= prev_stamp) begin
      div_in.rem = time_q - prev_stamp;
      div_in.den = cur_stamp - prev_stamp;
    end else begin
      div_in.rem = '0;
      div_in.den = WORD_W'(1);
    end
  end

  ktls_div_chain u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .link_i (div_in),
    .link_o (div_out)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc_sample) state_d = ST_SCAN;
      ST_SCAN: begin
        if (done_found) begin
          state_d = ST_DIV;
        end else if (done_clamp) begin
          state_d = ST_MUL;
        end
      end
      ST_DIV:  if (div_out.vld) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dv_q        <= 1'b0;
      ra_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_sample) begin
        ra_q <= '0;
        dv_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        dv_q <= 1'b1;
        if (ra_q != last_idx) begin
          ra_q <= ra_q + AW'(1);
        end
      end
      if (state_q == ST_ADD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_sample) begin
      time_q <= sample_time_i;
    end
    if (state_q == ST_SCAN) begin
      idx_q <= ra_q;
      if (dv_q) begin
        prev_q <= rd_q;
      end
    end
    if (done_clamp) begin
      a_q    <= sel_key;
      b_q    <= sel_key;
      frac_q <= '0;
      flag_q <= sel_flag;
    end else if (done_found) begin
      a_q    <= prev_q[3*WORD_W-1:0];
      b_q    <= rd_q[3*WORD_W-1:0];
      flag_q <= 1'b0;
    end
    if (state_q == ST_DIV && div_out.vld) begin
      frac_q <= div_out.quo;
    end
    if (state_q == ST_ADD && out_free) begin
      ox_q <= rx;
      oy_q <= ry;
      oz_q <= rz;
      oc_q <= flag_q;
    end
  end

  // per-axis interpolation
  ktls_lerp_axis u_lerp_x (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_MUL),
    .a_i      (a_q[3*WORD_W-1 -: WORD_W]),
    .b_i      (b_q[3*WORD_W-1 -: WORD_W]),
    .frac_i   (frac_q),
    .res_o    (rx)
  );

  ktls_lerp_axis u_lerp_y (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_MUL),
    .a_i      (a_q[2*WORD_W-1 -: WORD_W]),
    .b_i      (b_q[2*WORD_W-1 -: WORD_W]),
    .frac_i   (frac_q),
    .res_o    (ry)
  );

  ktls_lerp_axis u_lerp_z (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_MUL),
    .a_i      (a_q[WORD_W-1:0]),
    .b_i      (b_q[WORD_W-1:0]),
    .frac_i   (frac_q),
    .res_o    (rz)
  );

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign clamped_o   = oc_q;

  // checks on sequencing
  `KTLS_ASSERT_NXT(a_sample_starts_scan, acc_sample, state_q == ST_SCAN)
  `KTLS_ASSERT_IMP(a_div_done_in_div, div_out.vld, state_q == ST_DIV)
  `KTLS_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN && dv_q, idx_q <= last_idx)
  `KTLS_ASSERT_NXT(a_add_delivers, state_q == ST_ADD && out_free, out_valid_o)

endmodule

FILE: test/tb_keyframe_track_lerp_sampler_top.sv
// ----------------------------------------------------------------------------
// tb_keyframe_track_lerp_sampler_top
// self-checking bench: loads key tables, samples the track at random and
// edge times, and compares every result with an in-bench interpolator
// ----------------------------------------------------------------------------
module tb_keyframe_track_lerp_sampler_top;
  import ktls_pkg::*;

  localparam int unsigned NKEYS = 64;
  localparam int unsigned LAT   = 120;

  typedef struct {
    logic              cmd;
    logic [5:0]        slot;
    logic [31:0]       stamp;
    logic [31:0]       kx;
    logic [31:0]       ky;
    logic [31:0]       kz;
    logic [31:0]       t;
  } req_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clamped;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [KCNT_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = CMD_LOAD;
  logic [SLOT_W-1:0] key_slot_i = '0;
  logic [WORD_W-1:0] key_stamp_i = '0;
  logic signed [WORD_W-1:0] key_x_i = '0, key_y_i = '0, key_z_i = '0;
  logic [WORD_W-1:0] sample_time_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [WORD_W-1:0] out_x_o, out_y_o, out_z_o;
  logic clamped_o;

  keyframe_track_lerp_sampler_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .cmd_i, .key_slot_i, .key_stamp_i, .key_x_i, .key_y_i, .key_z_i,
    .sample_time_i, .out_valid_o, .out_ready_i, .out_x_o, .out_y_o,
    .out_z_o, .clamped_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow track state
  logic [31:0] stamp_mem [NKEYS];
  logic [31:0] x_mem [NKEYS];
  logic [31:0] y_mem [NKEYS];
  logic [31:0] z_mem [NKEYS];
  logic [6:0]  track_len;

  req_t  req_q [$];
  pose_t pose_q [$];
  int    mismatches = 0;
  bit    calm = 1'b0;

  function automatic logic [31:0] lerp_axis(logic [31:0] ra, logic [31:0] rb,
                                            logic [15:0] f);
    longint a, b, p, q, r;
    a = longint'(signed'(ra));
    b = longint'(signed'(rb));
    p = (b - a) * longint'({1'b0, f});
    q = p >>> 16;
    r = a + q;
    if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
    if (r < -64'sh80000000) r = -64'sh80000000;
    return r[31:0];
  endfunction

  function automatic pose_t key_pose(int k, logic flag);
    pose_t p;
    p.x = x_mem[k];
    p.y = y_mem[k];
    p.z = z_mem[k];
    p.clamped = flag;
    return p;
  endfunction

  // apply one accepted request to the shadow track
  function automatic void track_apply(req_t r);
    int n, seg;
    bit found;
    logic [15:0] f;
    pose_t p;
    logic [63:0] num, den;
    if (r.cmd == CMD_LOAD) begin
      stamp_mem[r.slot] = r.stamp;
      x_mem[r.slot] = r.kx;
      y_mem[r.slot] = r.ky;
      z_mem[r.slot] = r.kz;
      return;
    end
    n = track_len;
    if (n == 0) n = 1;
    if (n > NKEYS) n = NKEYS;
    if (n == 1) begin
      pose_q.push_back(key_pose(0, 1'b0));
      return;
    end
    if (r.t < stamp_mem[0]) begin
      pose_q.push_back(key_pose(0, 1'b1));
      return;
    end
    found = 0;
    seg = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && r.t < stamp_mem[i+1]) begin
        seg = i;
        found = 1;
      end
    end
    if (!found) begin
      pose_q.push_back(key_pose(n - 1, 1'b1));
      return;
    end
    if (r.t >= stamp_mem[seg]) begin
      num = {32'd0, r.t - stamp_mem[seg]} << 16;
      den = {32'd0, stamp_mem[seg+1] - stamp_mem[seg]};
      f = 16'(num / den);
    end else begin
      f = '0;
    end
    p.x = lerp_axis(x_mem[seg], x_mem[seg+1], f);
    p.y = lerp_axis(y_mem[seg], y_mem[seg+1], f);
    p.z = lerp_axis(z_mem[seg], z_mem[seg+1], f);
    p.clamped = 1'b0;
    pose_q.push_back(p);
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t mk_load(int slot, logic [31:0] s);
    req_t r;
    r.cmd = CMD_LOAD;
    r.slot = 6'(slot);
    r.stamp = s;
    r.kx = rnd_word();
    r.ky = rnd_word();
    r.kz = rnd_word();
    r.t = $urandom;
    return r;
  endfunction

  function automatic req_t mk_sample(logic [31:0] t);
    req_t r;
    r = mk_load($urandom_range(0, 63), $urandom);
    r.cmd = CMD_SAMPLE;
    r.t = t;
    return r;
  endfunction

  // driver bookkeeping
  int in_gap = 0;
  bit accepted_last = 1'b0;

  // accepted requests are folded into the prediction on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      track_apply(req_q.pop_front());
    end
  end

  always @(posedge clk_i) accepted_last <= rst_ni && in_valid_i && in_ready_o;

  // drive the next request on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_last) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_valid_i <= 1'b1;
          cmd_i <= req_q[0].cmd;
          key_slot_i <= req_q[0].slot;
          key_stamp_i <= req_q[0].stamp;
          key_x_i <= req_q[0].kx;
          key_y_i <= req_q[0].ky;
          key_z_i <= req_q[0].kz;
          sample_time_i <= req_q[0].t;
          if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h", out_x_o);
      end else begin
        e = pose_q.pop_front();
        if (out_x_o !== e.x || out_y_o !== e.y || out_z_o !== e.z ||
            clamped_o !== e.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %b got %h %h %h %b", e.x, e.y, e.z,
                     e.clamped, out_x_o, out_y_o, out_z_o, clamped_o);
        end
      end
    end
  end

  // receiver stalls
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      out_gap <= $urandom_range(1, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  task automatic wait_idle();
    while (req_q.size() > 0 || pose_q.size() > 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic set_len(int n);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(n);
    track_len = 7'(n);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // load a full table with ascending stamps, some repeated
  task automatic fill_track(logic [31:0] step);
    logic [31:0] s;
    s = $urandom_range(0, 1000);
    for (int k = 0; k < NKEYS; k++) begin
      req_q.push_back(mk_load(k, s));
      if ($urandom_range(0, 9) != 0) s = s + $urandom_range(1, step);
    end
  endtask

  function automatic logic [31:0] pick_time();
    int k;
    k = $urandom_range(0, NKEYS - 1);
    case ($urandom_range(0, 4))
      0: return stamp_mem[k];
      1: return stamp_mem[k] + $urandom_range(0, 3000);
      2: return stamp_mem[k] - 1;
      3: return rnd_word();
      default: return stamp_mem[k] + $urandom_range(0, 60000);
    endcase
  endfunction

  initial begin
    int lens [6] = '{1, 2, 64, 0, 127, 5};
    track_len = 7'd1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: full-range keys, extremes, one key, clamps, descending pair
    req_q.push_back(mk_load(0, 32'h0000_0000));
    req_q[0].kx = 32'h8000_0000; req_q[0].ky = 32'h7FFF_FFFF; req_q[0].kz = 32'h0;
    req_q.push_back(mk_load(1, 32'hFFFF_FFFF));
    req_q[1].kx = 32'h7FFF_FFFF; req_q[1].ky = 32'h8000_0000; req_q[1].kz = 32'hFFFF_FFFF;
    req_q.push_back(mk_load(2, 32'h0001_0000));
    req_q.push_back(mk_load(63, 32'hFFFF_FFFF));
    req_q.push_back(mk_sample(32'h0000_1234));
    wait_idle();
    set_len(2);
    req_q.push_back(mk_sample(32'h0000_0000));
    req_q.push_back(mk_sample(32'h7FFF_FFFF));
    req_q.push_back(mk_sample(32'hFFFF_FFFE));
    req_q.push_back(mk_sample(32'hFFFF_FFFF));
    wait_idle();
    set_len(3);
    req_q.push_back(mk_load(0, 32'h0000_1000));
    req_q.push_back(mk_load(1, 32'h0009_0000));
    req_q.push_back(mk_load(2, 32'h0002_0000));
    req_q.push_back(mk_sample(32'h0000_0000));
    req_q.push_back(mk_sample(32'h0005_0000));
    req_q.push_back(mk_sample(32'h0009_0000));
    req_q.push_back(mk_sample(32'h0000_1000));
    wait_idle();

    // random phases over several track lengths
    for (int ph = 0; ph < 6; ph++) begin
      set_len(lens[ph]);
      fill_track(ph[0] ? 32'd500 : 32'd200000);
      while (req_q.size() > 0) @(posedge clk_i);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 35; i++) begin
        if ($urandom_range(0, 7) == 0)
          req_q.push_back(mk_load($urandom_range(0, 63), $urandom));
        else
          req_q.push_back(mk_sample(pick_time()));
        while (req_q.size() > 4) @(posedge clk_i);
      end
      wait_idle();
    end

    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/ktls_pkg.sv
src/ktls_div_cell.sv
src/ktls_div_chain.sv
src/ktls_lerp_axis.sv
src/keyframe_track_lerp_sampler_top.sv
test/tb_keyframe_track_lerp_sampler_top.sv
